/* rtl/julian_day_to_calendar_time_core_assert.svh */
// Assertion macros shared by the Julian day converter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef JULIAN_DAY_TO_CALENDAR_TIME_CORE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_TIME_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDCT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must hold at every rising clock edge outside reset.
`define JDCT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

/* rtl/jdct_pkg.sv */
// Types, constants and calendar tables for the Julian day converter.
// Depends on nothing; used by every module of the converter.
`default_nettype none

package jdct_pkg;

   // Input item: whole day number and fraction of the day.
   typedef struct packed {
      logic [22:0] day_number;
      logic [31:0] day_fraction;
   } req_item_type;

   // Result item: calendar date and time of day.
   typedef struct packed {
      logic [13:0] cal_year;
      logic [3:0]  cal_month;
      logic [4:0]  cal_day;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
   } rsp_item_type;

   // Request into the date pipeline.
   typedef struct packed {
      logic [22:0] day_number;
      logic        day_carry;
   } date_req_type;

   // Date leaving the date pipeline.
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } cal_date_type;

   // Time of day leaving the time pipeline.
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } clock_time_type;

   // Pipeline depths; the time result is delayed to meet the date result.
   localparam int DATE_LATENCY = 14;
   localparam int TIME_LATENCY = 4;
   localparam int TIME_DELAY   = DATE_LATENCY - TIME_LATENCY;

   // First day number of the Gregorian calendar.
   localparam logic [22:0] JD_GREGORIAN_START = 23'd2299161;

   // Smallest fraction whose rounded seconds roll over into the next day.
   localparam logic [31:0] DAY_CARRY_MIN = 32'd4294942441;

   // Century term: (4a - 7468865) / 146097, via a reciprocal estimate.
   localparam logic [25:0] CENTURY_OFFSET = 26'd7468865;
   localparam logic [17:0] CENTURY_DIV    = 18'd146097;
   localparam logic [7:0]  CENTURY_RECIP  = 8'd229;

   // Year term: (20b - 2442) / 7305, via a reciprocal estimate.
   localparam logic [11:0] YEAR_OFFSET = 12'd2442;
   localparam logic [12:0] YEAR_DIV    = 13'd7305;
   localparam logic [15:0] YEAR_RECIP  = 16'd36746;

   // Remaining calendar constants.
   localparam logic [10:0] DAYS_PER_4_YEARS = 11'd1461;
   localparam logic [10:0] JD_BIAS          = 11'd1524;
   localparam logic [10:0] JD_BIAS_GREG     = 11'd1525;
   localparam logic [12:0] YEAR_BIAS        = 13'd4715;
   localparam logic [12:0] YEAR_BIAS_EARLY  = 13'd4716;
   localparam logic [3:0]  MONTH_WRAP       = 4'd13;

   // Time of day limits.
   localparam logic [4:0] LAST_HOUR          = 5'd23;
   localparam logic [5:0] LAST_MINUTE        = 6'd59;
   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

   // Smallest day count r for which (1000 r) / 30601 reaches k.
   function automatic logic [8:0] month_threshold(input logic [3:0] k);
      logic [8:0] thr;
      unique case (k)
         4'd1:    thr = 9'd31;
         4'd2:    thr = 9'd62;
         4'd3:    thr = 9'd92;
         4'd4:    thr = 9'd123;
         4'd5:    thr = 9'd154;
         4'd6:    thr = 9'd184;
         4'd7:    thr = 9'd215;
         4'd8:    thr = 9'd245;
         4'd9:    thr = 9'd276;
         4'd10:   thr = 9'd307;
         4'd11:   thr = 9'd337;
         4'd12:   thr = 9'd368;
         4'd13:   thr = 9'd398;
         4'd14:   thr = 9'd429;
         4'd15:   thr = 9'd460;
         default: thr = 9'd0;
      endcase
      return thr;
   endfunction

   // Day offset of month code e: (30601 e) / 1000.
   function automatic logic [8:0] month_start(input logic [3:0] e);
      logic [8:0] ms;
      unique case (e)
         4'd1:    ms = 9'd30;
         4'd2:    ms = 9'd61;
         4'd3:    ms = 9'd91;
         4'd4:    ms = 9'd122;
         4'd5:    ms = 9'd153;
         4'd6:    ms = 9'd183;
         4'd7:    ms = 9'd214;
         4'd8:    ms = 9'd244;
         4'd9:    ms = 9'd275;
         4'd10:   ms = 9'd306;
         4'd11:   ms = 9'd336;
         4'd12:   ms = 9'd367;
         4'd13:   ms = 9'd397;
         4'd14:   ms = 9'd428;
         4'd15:   ms = 9'd459;
         default: ms = 9'd0;
      endcase
      return ms;
   endfunction

endpackage

`default_nettype wire

/* rtl/jdct_time.sv */
// Time of day pipeline: splits the day fraction into hour, minute and second.
// Depends on jdct_pkg and the shared assertion macros.
`default_nettype none
`include "julian_day_to_calendar_time_core_assert.svh"

module jdct_time (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [31:0]              in_fraction,
   output logic                     out_valid,
   output jdct_pkg::clock_time_type out_time
);
   import jdct_pkg::*;

   logic [TIME_LATENCY-1:0] valid_ff;

   logic [4:0]  hour1_ff, hour2_ff, hour3_ff;
   logic [31:0] rem1_ff, rem2_ff;
   logic [5:0]  min2_ff, min3_ff;
   logic [5:0]  sec3_ff;
   clock_time_type time_ff, time_in;

   logic [36:0] prod1;
   logic [37:0] prod2, prod3;

   // Constant multiplies: each stage peels off one unit of time.
   always_comb begin
      prod1 = 37'(in_fraction) * 37'd24;
      prod2 = 38'(rem1_ff) * 38'd60;
      prod3 = 38'(rem2_ff) * 38'd60 + 38'h0_8000_0000;
   end

   // Seconds that round up to sixty carry into the minute and then the hour.
   always_comb begin
      time_in.hour   = hour3_ff;
      time_in.minute = min3_ff;
      time_in.second = sec3_ff;
      if (sec3_ff == SECONDS_PER_MINUTE) begin
         time_in.second = '0;
         if (min3_ff == LAST_MINUTE) begin
            time_in.minute = '0;
            time_in.hour   = (hour3_ff == LAST_HOUR) ? 5'd0 : hour3_ff + 5'd1;
         end else begin
            time_in.minute = min3_ff + 6'd1;
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[TIME_LATENCY-2:0], in_valid};
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      hour1_ff <= prod1[36:32];
      rem1_ff  <= prod1[31:0];
      hour2_ff <= hour1_ff;
      min2_ff  <= prod2[37:32];
      rem2_ff  <= prod2[31:0];
      hour3_ff <= hour2_ff;
      min3_ff  <= min2_ff;
      sec3_ff  <= prod3[37:32];
      time_ff  <= time_in;
   end

   assign out_valid = valid_ff[TIME_LATENCY-1];
   assign out_time  = time_ff;

   `JDCT_ASSERT_IMPLY(a_time_range, clock, reset, out_valid,
      (out_time.hour < 5'd24) && (out_time.minute < 6'd60) && (out_time.second < 6'd60),
      "time of day out of range")
   `JDCT_ASSERT_IMPLY(a_time_latency, clock, reset, out_valid,
      $past(in_valid, TIME_LATENCY), "time result without a matching item")
   `JDCT_ASSERT_IMPLY(a_time_midnight, clock, reset,
      out_valid && ($past(in_fraction, TIME_LATENCY) == 32'd0),
      (out_time.hour == 5'd0) && (out_time.minute == 6'd0) && (out_time.second == 6'd0),
      "zero fraction does not give midnight")

endmodule

`default_nettype wire

/* rtl/jdct_date.sv */
// Date pipeline: Julian day number to calendar year, month and day.
// Depends on jdct_pkg and the shared assertion macros.
`default_nettype none
`include "julian_day_to_calendar_time_core_assert.svh"

module jdct_date (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  jdct_pkg::date_req_type in_req,
   output logic                   out_valid,
   output jdct_pkg::cal_date_type out_date
);
   import jdct_pkg::*;

   logic [DATE_LATENCY-1:0] valid_ff;

   // Stage registers, numbered by stage.
   logic [23:0] a1_ff, a2_ff, a3_ff, a4_ff, a5_ff;
   logic        greg2_ff, greg3_ff, greg4_ff, greg5_ff;
   logic [24:0] n1_2_ff, n1_3_ff, n1_4_ff;
   logic [7:0]  cq3_ff, cq4_ff, c5_ff;
   logic [25:0] cprod4_ff;
   logic [23:0] b6_ff, b7_ff, b8_ff, b9_ff, b10_ff, b11_ff;
   logic [27:0] n2_7_ff, n2_8_ff, n2_9_ff;
   logic [14:0] yq8_ff, yq9_ff, y10_ff, y11_ff, y12_ff, y13_ff;
   logic [27:0] yprod9_ff;
   logic [25:0] ys11_ff;
   logic [8:0]  r12_ff, r13_ff;
   logic [3:0]  e13_ff;
   cal_date_type date_ff;

   // Next values.
   logic [23:0] a1_in, b6_in;
   logic [25:0] n1_full;
   logic [32:0] cmul;
   logic [25:0] cprod4_in, crem;
   logic [7:0]  c5_in;
   logic [27:0] n2_7_in, yprod9_in, yrem;
   logic [43:0] ymul;
   logic [14:0] y10_in;
   logic [25:0] ys11_in;
   logic [23:0] rdiff;
   logic [3:0]  e13_in;
   logic [8:0]  mday;
   logic [14:0] year_full;
   cal_date_type date_in;

   // Day carry and the century quotient: estimate, multiply back and correct.
   always_comb begin
      a1_in     = {1'b0, in_req.day_number} + 24'(in_req.day_carry);
      n1_full   = {a1_ff, 2'b00} - CENTURY_OFFSET;
      cmul      = 33'(n1_2_ff) * 33'(CENTURY_RECIP);
      cprod4_in = 26'(cq3_ff) * 26'(CENTURY_DIV);
      // The estimate is at most one short: one compare settles it.
      crem      = 26'(n1_4_ff) - cprod4_ff;
      c5_in     = cq4_ff + 8'(crem >= 26'(CENTURY_DIV));
   end

   // Gregorian correction and the shifted day count.
   always_comb begin
      if (greg5_ff) begin
         b6_in = a5_ff + 24'(JD_BIAS_GREG) + 24'(c5_ff) - 24'(c5_ff[7:2]);
      end else begin
         b6_in = a5_ff + 24'(JD_BIAS);
      end
   end

   // Year quotient: estimate by reciprocal, then correct by one.
   always_comb begin
      n2_7_in   = ({4'b0, b6_ff} << 4) + ({4'b0, b6_ff} << 2) - 28'(YEAR_OFFSET);
      ymul      = 44'(n2_7_ff) * 44'(YEAR_RECIP);
      yprod9_in = 28'(yq8_ff) * 28'(YEAR_DIV);
      yrem      = n2_9_ff - yprod9_ff;
      y10_in    = yq9_ff + 15'(yrem >= 28'(YEAR_DIV));
      ys11_in   = 26'(y10_ff) * 26'(DAYS_PER_4_YEARS);
      rdiff     = b11_ff - ys11_ff[25:2];
   end

   // Month code from the day count by a row of constant compares.
   always_comb begin
      e13_in = '0;
      for (int k = 1; k < 16; k++) begin
         if (r12_ff >= month_threshold(4'(k))) begin
            e13_in = 4'(k);
         end
      end
   end

   // Day of month, month and year, with the year wrapped to its width.
   always_comb begin
      mday        = r13_ff - month_start(e13_ff);
      date_in.day = mday[4:0];
      if (e13_ff > MONTH_WRAP) begin
         date_in.month = e13_ff - MONTH_WRAP;
         year_full     = y13_ff - 15'(YEAR_BIAS);
      end else begin
         date_in.month = e13_ff - 4'd1;
         year_full     = y13_ff - 15'(YEAR_BIAS_EARLY);
      end
      date_in.year = year_full[13:0];
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DATE_LATENCY-2:0], in_valid};
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      a1_ff     <= a1_in;
      a2_ff     <= a1_ff;
      greg2_ff  <= a1_ff >= 24'(JD_GREGORIAN_START);
      n1_2_ff   <= n1_full[24:0];
      a3_ff     <= a2_ff;
      greg3_ff  <= greg2_ff;
      n1_3_ff   <= n1_2_ff;
      cq3_ff    <= cmul[32:25];
      a4_ff     <= a3_ff;
      greg4_ff  <= greg3_ff;
      n1_4_ff   <= n1_3_ff;
      cq4_ff    <= cq3_ff;
      cprod4_ff <= cprod4_in;
      a5_ff     <= a4_ff;
      greg5_ff  <= greg4_ff;
      c5_ff     <= c5_in;
      b6_ff     <= b6_in;
      b7_ff     <= b6_ff;
      n2_7_ff   <= n2_7_in;
      b8_ff     <= b7_ff;
      n2_8_ff   <= n2_7_ff;
      yq8_ff    <= ymul[42:28];
      b9_ff     <= b8_ff;
      n2_9_ff   <= n2_8_ff;
      yq9_ff    <= yq8_ff;
      yprod9_ff <= yprod9_in;
      b10_ff    <= b9_ff;
      y10_ff    <= y10_in;
      b11_ff    <= b10_ff;
      y11_ff    <= y10_ff;
      ys11_ff   <= ys11_in;
      y12_ff    <= y11_ff;
      r12_ff    <= rdiff[8:0];
      y13_ff    <= y12_ff;
      r13_ff    <= r12_ff;
      e13_ff    <= e13_in;
      date_ff   <= date_in;
   end

   assign out_valid = valid_ff[DATE_LATENCY-1];
   assign out_date  = date_ff;

   `JDCT_ASSERT_IMPLY(a_date_range, clock, reset, out_valid,
      (out_date.month >= 4'd1) && (out_date.month <= 4'd12) && (out_date.day >= 5'd1),
      "calendar month or day out of range")
   `JDCT_ASSERT_IMPLY(a_date_latency, clock, reset, out_valid,
      $past(in_valid, DATE_LATENCY), "date result without a matching item")
   `JDCT_ASSERT_IMPLY(a_date_reform, clock, reset,
      out_valid && ($past(in_req.day_number, DATE_LATENCY) == JD_GREGORIAN_START)
         && !$past(in_req.day_carry, DATE_LATENCY),
      (out_date.year == 14'd1582) && (out_date.month == 4'd10) && (out_date.day == 5'd15),
      "first Gregorian day is not 1582-10-15")

endmodule

`default_nettype wire

/* rtl/julian_day_to_calendar_time_core.sv */
// Top level of the Julian day to calendar date and time converter.
// Depends on jdct_pkg, jdct_time, jdct_date and the shared assertion macros.
//
//   Channel   Ports                     Handshake
//   --------  ------------------------  --------------------------------------
//   request   start, busy, req_item     taken when start is high, busy is low
//   response  rsp_strobe, rsp_item      one cycle per item, cannot be held off
//
// An item may be taken in every cycle; busy is never raised.
// The delay of each result is set by the depth of the date
// pipeline (two reciprocal divisions, each estimate, multiply and correct,
// followed by a row of month compares).
// The time of day is ready earlier and waits in a delay line.
// Reset is synchronous and clears only the valid bits.
`default_nettype none
`include "julian_day_to_calendar_time_core_assert.svh"

module julian_day_to_calendar_time_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  jdct_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output jdct_pkg::rsp_item_type rsp_item
);
   import jdct_pkg::*;

   logic           accept;
   date_req_type   date_req;
   logic           date_valid;
   cal_date_type   date_out;
   logic           time_valid;
   clock_time_type time_out;

   logic [TIME_DELAY-1:0] tvalid_dly_ff;
   clock_time_type        time_dly_ff [TIME_DELAY];

   // The pipeline never stalls, so every offered item is taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // A fraction that rounds up to the next midnight moves the date by one day.
   always_comb begin
      date_req.day_number = req_item.day_number;
      date_req.day_carry  = req_item.day_fraction >= DAY_CARRY_MIN;
   end

   jdct_time u_time (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_fraction (req_item.day_fraction),
      .out_valid   (time_valid),
      .out_time    (time_out)
   );

   jdct_date u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (date_req),
      .out_valid (date_valid),
      .out_date  (date_out)
   );

   // Delay line that brings the time of day level with the date.
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_dly_ff <= '0;
      end else begin
         tvalid_dly_ff <= {tvalid_dly_ff[TIME_DELAY-2:0], time_valid};
      end
   end

   always_ff @(posedge clock) begin
      time_dly_ff[0] <= time_out;
      for (int i = 1; i < TIME_DELAY; i++) begin
         time_dly_ff[i] <= time_dly_ff[i-1];
      end
   end

   // Result assembly.
   always_comb begin
      rsp_strobe                = date_valid;
      rsp_item.cal_year         = date_out.year;
      rsp_item.cal_month        = date_out.month;
      rsp_item.cal_day          = date_out.day;
      rsp_item.hour_of_day      = time_dly_ff[TIME_DELAY-1].hour;
      rsp_item.minute_of_hour   = time_dly_ff[TIME_DELAY-1].minute;
      rsp_item.second_of_minute = time_dly_ff[TIME_DELAY-1].second;
   end

   `JDCT_ASSERT_ALWAYS(a_paths_aligned, clock, reset,
      rsp_strobe == tvalid_dly_ff[TIME_DELAY-1], "date and time results out of step")
   `JDCT_ASSERT_IMPLY(a_rsp_from_item, clock, reset, rsp_strobe,
      $past(accept, DATE_LATENCY), "result without an accepted item")
   `JDCT_ASSERT_IMPLY(a_full_day_wraps, clock, reset,
      rsp_strobe && ($past(req_item.day_fraction, DATE_LATENCY) == 32'hFFFF_FFFF),
      (rsp_item.hour_of_day == 5'd0) && (rsp_item.minute_of_hour == 6'd0)
         && (rsp_item.second_of_minute == 6'd0),
      "end of day does not roll over to midnight")

endmodule

`default_nettype wire

/* test/tb_julian_day_to_calendar_time_core.sv */
// Self-checking testbench for the Julian day to calendar date and time converter.
// Depends on jdct_pkg and julian_day_to_calendar_time_core; it reads no files.
`timescale 1ns / 100ps

module tb_julian_day_to_calendar_time_core;
   import jdct_pkg::*;

   // Run shape.
   localparam int RANDOM_ITEMS  = 1730;
   localparam int CALM_ITEMS    = 200;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 32;

   // Day numbers of 1 January of year 1 and 31 December of year 9999.
   localparam int EARLIEST_DAY = 1721424;
   localparam int LATEST_DAY   = 5373484;

   // Ways of drawing a random item.
   typedef enum int {
      DRAW_ANY,
      DRAW_SECOND_BOUNDARY,
      DRAW_CALENDAR_SWITCH,
      DRAW_RANGE_END,
      DRAW_IN_RANGE
   } draw_kind_type;

   // One row of the directed table; the result is typed in where it is obvious.
   typedef struct {
      req_item_type stim;
      bit           has_golden;
      rsp_item_type golden;
   } directed_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // What the item now on offer should produce when the table gives it.
   bit           offer_has_golden;
   rsp_item_type offer_golden;

   directed_row_type directed_rows[$];
   rsp_item_type     pending_dates[$];
   rsp_item_type     want;

   int mismatches;
   int items_accepted;
   int results_checked;
   int julian_items;
   int rollover_items;
   int quiet_cycles;

   julian_day_to_calendar_time_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // Free-running clock, 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Date and time of one item, worked out in exact integer arithmetic.
   function automatic rsp_item_type calendar_of(input req_item_type item);
      rsp_item_type     res;
      longint unsigned  prod;
      longint unsigned  hr;
      longint unsigned  mn;
      longint unsigned  sc;
      longint           dn;
      longint           a;
      longint           cen;
      longint           b;
      longint           yr;
      longint           rem;
      longint           mcode;
      longint           mon;
      prod = {32'd0, item.day_fraction};
      prod = prod * 24;
      hr   = prod >> 32;
      prod = (prod & 64'hFFFF_FFFF) * 60;
      mn   = prod >> 32;
      prod = (prod & 64'hFFFF_FFFF) * 60;
      sc   = (prod + 64'h8000_0000) >> 32;
      dn   = {41'd0, item.day_number};

      // Seconds that round to sixty ripple up, possibly into the next day.
      if (sc >= 60) begin
         sc = 0;
         mn = mn + 1;
         if (mn >= 60) begin
            mn = 0;
            hr = hr + 1;
            if (hr >= 24) begin
               hr = 0;
               dn = dn + 1;
            end
         end
      end

      // Day number to date; the Gregorian correction applies from its first day.
      a = dn;
      if (a >= longint'(JD_GREGORIAN_START)) begin
         cen = (4 * a - 7468865) / 146097;
         a   = a + 1 + cen - cen / 4;
      end
      b     = a + 1524;
      yr    = (20 * b - 2442) / 7305;
      rem   = b - (1461 * yr) / 4;
      mcode = (1000 * rem) / 30601;
      rem   = rem - (30601 * mcode) / 1000;
      if (mcode > 13) begin
         mon = mcode - 13;
      end else begin
         mon = mcode - 1;
         yr  = yr - 1;
      end
      yr = yr - 4715;

      res.cal_year         = yr[13:0];
      res.cal_month        = mon[3:0];
      res.cal_day          = rem[4:0];
      res.hour_of_day      = hr[4:0];
      res.minute_of_hour   = mn[5:0];
      res.second_of_minute = sc[5:0];
      return res;
   endfunction

   function automatic void add_row(input int day, input logic [31:0] frac, input bit has_golden,
                                   input int yr, input int mon, input int mday,
                                   input int hr, input int mn, input int sc);
      directed_row_type row;
      row.stim.day_number          = day[22:0];
      row.stim.day_fraction        = frac;
      row.has_golden               = has_golden;
      row.golden.cal_year          = yr[13:0];
      row.golden.cal_month         = mon[3:0];
      row.golden.cal_day           = mday[4:0];
      row.golden.hour_of_day       = hr[4:0];
      row.golden.minute_of_hour    = mn[5:0];
      row.golden.second_of_minute  = sc[5:0];
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Random item; much of the weight sits on rounding boundaries and calendar seams.
   function automatic req_item_type random_item();
      req_item_type  item;
      draw_kind_type kind;
      longint        boundary;
      int            sec;
      int            pick;
      item.day_number   = 23'($urandom_range(EARLIEST_DAY, LATEST_DAY));
      item.day_fraction = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 3)      kind = DRAW_ANY;
      else if (pick < 6) kind = DRAW_SECOND_BOUNDARY;
      else if (pick < 7) kind = DRAW_CALENDAR_SWITCH;
      else if (pick < 8) kind = DRAW_RANGE_END;
      else               kind = DRAW_IN_RANGE;
      case (kind)
         DRAW_ANY: begin
            item.day_number = 23'($urandom);
         end
         DRAW_SECOND_BOUNDARY: begin
            // Close to a half second, where the rounding of seconds flips.
            sec      = $urandom_range(0, 86399);
            boundary = ((2 * longint'(sec) + 1) << 32) / 172800;
            boundary = boundary + $urandom_range(0, 8191) - 4096;
            item.day_fraction = boundary[31:0];
         end
         DRAW_CALENDAR_SWITCH: begin
            item.day_number = 23'(JD_GREGORIAN_START - 400 + $urandom_range(0, 800));
            if ($urandom_range(0, 1) == 0) begin
               item.day_fraction = 32'hFFFF_FFFF - $urandom_range(0, 60000);
            end
         end
         DRAW_RANGE_END: begin
            if ($urandom_range(0, 1) == 0) begin
               item.day_number = 23'(EARLIEST_DAY - 20 + $urandom_range(0, 40));
            end else begin
               item.day_number = 23'(LATEST_DAY - 20 + $urandom_range(0, 40));
            end
            if ($urandom_range(0, 1) == 0) begin
               item.day_fraction = 32'hFFFF_FFFF - $urandom_range(0, 60000);
            end
         end
         default: begin
         end
      endcase
      return item;
   endfunction

   // Offer one item at the falling edge and hold it until it is taken.
   task automatic offer(input req_item_type item, input bit has_golden,
                        input rsp_item_type golden);
      start            <= 1'b1;
      req_item         <= item;
      offer_has_golden  = has_golden;
      offer_golden      = golden;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // A short gap on the request side, with noise on the idle payload.
   task automatic idle_burst();
      req_item_type noise;
      noise.day_number   = 23'($urandom);
      noise.day_fraction = $urandom;
      start    <= 1'b0;
      req_item <= noise;
      repeat ($urandom_range(1, 3)) @(negedge clock);
   endtask

   // Hold back new items until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   // Compare each result with the oldest expectation, then record newly taken items.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_dates.size() == 0) begin
               $error("Result arrived with no item outstanding");
               mismatches++;
            end else begin
               want = pending_dates.pop_front();
               results_checked++;
               if (rsp_item.cal_year !== want.cal_year) begin
                  $error("cal_year: expected %0d, got %0d", want.cal_year, rsp_item.cal_year);
                  mismatches++;
               end
               if (rsp_item.cal_month !== want.cal_month) begin
                  $error("cal_month: expected %0d, got %0d", want.cal_month,
                         rsp_item.cal_month);
                  mismatches++;
               end
               if (rsp_item.cal_day !== want.cal_day) begin
                  $error("cal_day: expected %0d, got %0d", want.cal_day, rsp_item.cal_day);
                  mismatches++;
               end
               if (rsp_item.hour_of_day !== want.hour_of_day) begin
                  $error("hour_of_day: expected %0d, got %0d", want.hour_of_day,
                         rsp_item.hour_of_day);
                  mismatches++;
               end
               if (rsp_item.minute_of_hour !== want.minute_of_hour) begin
                  $error("minute_of_hour: expected %0d, got %0d", want.minute_of_hour,
                         rsp_item.minute_of_hour);
                  mismatches++;
               end
               if (rsp_item.second_of_minute !== want.second_of_minute) begin
                  $error("second_of_minute: expected %0d, got %0d", want.second_of_minute,
                         rsp_item.second_of_minute);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            pending_dates.insert(pending_dates.size(),
                                 offer_has_golden ? offer_golden : calendar_of(req_item));
            items_accepted++;
            if (req_item.day_number < JD_GREGORIAN_START) julian_items++;
            if (req_item.day_fraction >= DAY_CARRY_MIN) rollover_items++;
         end
      end
   end

   // Watchdog: too long without any item or result moving ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Stimulus: directed table, then random items, then a drained finish.
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_item         = '0;
      offer_has_golden = 1'b0;
      offer_golden     = '0;

      // Known dates, the ends of the range and the switch between calendars.
      add_row(2451545, 32'h0000_0000, 1'b1, 2000, 1, 1, 0, 0, 0);
      add_row(2451545, 32'h8000_0000, 1'b1, 2000, 1, 1, 12, 0, 0);
      add_row(EARLIEST_DAY, 32'h0000_0000, 1'b1, 1, 1, 1, 0, 0, 0);
      add_row(LATEST_DAY, 32'h0000_0000, 1'b1, 9999, 12, 31, 0, 0, 0);
      add_row(2299160, 32'h0000_0000, 1'b1, 1582, 10, 4, 0, 0, 0);
      add_row(2299161, 32'h0000_0000, 1'b1, 1582, 10, 15, 0, 0, 0);
      // Rounding that rolls over midnight, across the calendar switch and past 9999.
      add_row(2299160, 32'hFFFF_FFFF, 1'b1, 1582, 10, 15, 0, 0, 0);
      add_row(LATEST_DAY, 32'hFFFF_FFFF, 1'b1, 10000, 1, 1, 0, 0, 0);
      // Seconds carry into the minute, the hour and the day, and just short of it.
      add_row(2451545, DAY_CARRY_MIN, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(2451545, DAY_CARRY_MIN - 1, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(2451545, 32'd2962732, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(2451545, 32'd178937088, 1'b0, 0, 0, 0, 0, 0, 0);
      // Day numbers outside the calendar range, with the year wrapping.
      add_row(0, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(23'h7F_FFFF, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(EARLIEST_DAY - 1, 32'h1234_5678, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(LATEST_DAY + 1, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 0, 0);
      // Alternating bit patterns and a leap day.
      add_row(23'h55_5555, 32'hAAAA_AAAA, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(23'h2A_AAAA, 32'h5555_5555, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(2451604, 32'h0000_0000, 1'b0, 0, 0, 0, 0, 0, 0);
      add_row(2299159, 32'hC000_0000, 1'b0, 0, 0, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].stim, directed_rows[i].has_golden, directed_rows[i].golden);
         if ($urandom_range(0, 2) == 0) idle_burst();
      end
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain();
         offer(random_item(), 1'b0, '0);
         // Gaps come in some stretches only, and never in the closing stretch.
         if (i < RANDOM_ITEMS - CALM_ITEMS && (i / 100) % 3 != 2 &&
             $urandom_range(0, 3) == 0) begin
            idle_burst();
         end
      end
      start <= 1'b0;

      while (pending_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d items, %0d of them from the directed table; %0d results compared.",
               items_accepted, directed_rows.size(), results_checked);
      $display("%0d items fell before the Gregorian switch and %0d rounded into the next day.",
               julian_items, rollover_items);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
